>>> design/lwbc_pkg.sv
// Shared types and constants of the LRU write-back cache set.
// Used by lwbc_cell and lru_write_back_cache_set_top; depends on nothing.

package lwbc_pkg;

   // Address width of a cache line tag
   localparam int ADDR_W = 32;
   // Way index and recency rank fields, sized for the largest supported set (64 ways)
   localparam int IDX_W  = 6;

   // Probe token handed from cell to cell during a lookup
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic [IDX_W-1:0]  hit_rank;
      logic [IDX_W-1:0]  vic_idx;
      logic [IDX_W-1:0]  vic_rank;
      logic              vic_dirty;
   } tok_type;

   // Update broadcast to every cell once the lookup is resolved
   typedef struct packed {
      logic              apply;
      logic [IDX_W-1:0]  idx;
      logic              hit;
      logic              is_write;
      logic [ADDR_W-1:0] addr;
      logic              old_valid;
      logic [IDX_W-1:0]  old_rank;
   } upd_type;

endpackage

>>> design/lwbc_cell.sv
// One way of the cache set: tag, valid, dirty and recency rank, plus one probe stage.
// Depends on lwbc_pkg for the token and update structs.

module lwbc_cell
   import lwbc_pkg::*;
#(
   parameter int WAYS       = 8,
   parameter int CELL_INDEX = 0
) (
   input  logic    clock,
   input  logic    reset,
   input  tok_type tok_in,
   output tok_type tok_out,
   input  upd_type upd
);

   localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic [ADDR_W-1:0] addr_ff;
   logic              valid_ff;
   logic              dirty_ff;
   logic [RANK_W-1:0] rank_ff;
   tok_type           tok_ff;
   tok_type           tok_in_next;
   logic [IDX_W-1:0]  rank_ext;

   assign rank_ext = IDX_W'(rank_ff);
   assign tok_out  = tok_ff;

   // Fold this way into the probe: first match wins, highest rank wins, ties stay low
   always_comb begin
      tok_in_next = tok_in;
      if (!tok_in.hit && valid_ff && (addr_ff == tok_in.addr)) begin
         tok_in_next.hit      = 1'b1;
         tok_in_next.hit_idx  = MY_IDX;
         tok_in_next.hit_rank = rank_ext;
      end
      if ((CELL_INDEX == 0) || (rank_ext > tok_in.vic_rank)) begin
         tok_in_next.vic_idx   = MY_IDX;
         tok_in_next.vic_rank  = rank_ext;
         tok_in_next.vic_dirty = dirty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.addr      <= tok_in_next.addr;
      tok_ff.hit       <= tok_in_next.hit;
      tok_ff.hit_idx   <= tok_in_next.hit_idx;
      tok_ff.hit_rank  <= tok_in_next.hit_rank;
      tok_ff.vic_idx   <= tok_in_next.vic_idx;
      tok_ff.vic_rank  <= tok_in_next.vic_rank;
      tok_ff.vic_dirty <= tok_in_next.vic_dirty;
   end

   // Apply the resolved access: the touched way goes to rank zero, more recent ways age
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dirty_ff <= 1'b0;
         rank_ff  <= '0;
      end else if (upd.apply) begin
         if (upd.idx == MY_IDX) begin
            rank_ff <= '0;
            if (upd.hit) begin
               dirty_ff <= dirty_ff | upd.is_write;
            end else begin
               valid_ff <= 1'b1;
               dirty_ff <= upd.is_write;
            end
         end else if (valid_ff && (!upd.old_valid || (rank_ext < upd.old_rank))) begin
            rank_ff <= rank_ff + RANK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (upd.apply && (upd.idx == MY_IDX) && !upd.hit) begin
         addr_ff <= upd.addr;
      end
   end

endmodule

>>> design/lru_write_back_cache_set_top.sv
// Top level of one LRU write-back cache set built as a chain of way cells.
// Depends on lwbc_pkg and lwbc_cell.
//
//   channel | direction | tdata                      | tuser
//   req_    | in        | [31:0] line_address        | [0] is_write
//   rsp_    | out       | [0] hit, [1] dirty_writeback | none
//
// Flow: an access beat walks the chain one way per cycle, and a new access is
// taken only after the previous lookup has been resolved and its result
// registered; the set never holds more than one lookup at a time.
// Reset clears the valid, dirty and rank state of every way and the fill count.
// A result held by rsp_tready low does not block the next request beat; only the
// update of a finished lookup waits for the result register to be free.

module lru_write_back_cache_set_top
   import lwbc_pkg::*;
#(
   parameter int WAYS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] line_address
   input  logic [0:0]  req_tuser,  // [0] is_write
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // [0] hit, [1] dirty_writeback, [7:2] zero
);

   localparam int CNT_W = $clog2(WAYS + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  fill_count_ff, fill_count_in;
   logic              write_ff;
   tok_type           done_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_wb_ff;

   tok_type           chain [WAYS+1];
   logic [WAYS-1:0]   chain_valid;
   upd_type           upd;

   logic              req_beat;
   logic              rsp_free;
   logic              full;
   logic              wb;

   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign full       = (fill_count_ff == CNT_W'(WAYS));

   // Inject a fresh probe at the head of the chain
   always_comb begin
      chain[0]           = '0;
      chain[0].valid     = req_beat;
      chain[0].addr      = req_tdata;
   end

   for (genvar g = 0; g < WAYS; g++) begin : g_way
      lwbc_cell #(
         .WAYS       (WAYS),
         .CELL_INDEX (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (chain[g]),
         .tok_out (chain[g+1]),
         .upd     (upd)
      );
      assign chain_valid[g] = chain[g+1].valid;
   end

   // Resolve the finished probe: hit way, next empty way, or the LRU victim
   always_comb begin
      upd.apply    = (state_ff == S_DONE) && rsp_free;
      upd.hit      = done_ff.hit;
      upd.is_write = write_ff;
      upd.addr     = done_ff.addr;
      upd.old_valid = done_ff.hit || full;
      if (done_ff.hit) begin
         upd.idx      = done_ff.hit_idx;
         upd.old_rank = done_ff.hit_rank;
      end else if (full) begin
         upd.idx      = done_ff.vic_idx;
         upd.old_rank = done_ff.vic_rank;
      end else begin
         upd.idx      = IDX_W'(fill_count_ff);
         upd.old_rank = '0;
      end
   end

   assign wb = !done_ff.hit && full && done_ff.vic_dirty;

   always_comb begin
      state_in      = state_ff;
      fill_count_in = fill_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (chain[WAYS].valid) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (!done_ff.hit && !full) begin
                  fill_count_in = fill_count_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers: hold the access kind, catch the probe at the chain tail
   always_ff @(posedge clock) begin
      if (req_beat) begin
         write_ff <= req_tuser[0];
      end
      if ((state_ff == S_SCAN) && chain[WAYS].valid) begin
         done_ff <= chain[WAYS];
      end
      if (upd.apply) begin
         rsp_hit_ff <= done_ff.hit;
         rsp_wb_ff  <= wb;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_wb_ff, rsp_hit_ff};

   // Only one probe may be in the chain at any time
   a_one_probe: assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_valid))
      else $error("more than one probe in the way chain");

   // A probe reaches the tail only while a lookup is in progress
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      chain[WAYS].valid |-> (state_ff == S_SCAN))
      else $error("probe left the chain outside a lookup");

   // The fill count never passes the number of ways
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CNT_W'(WAYS))
      else $error("fill count beyond way count");

   // A writeback is reported only on a miss
   a_wb_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("writeback reported on a hit");

endmodule

>>> bench/lru_write_back_cache_set_top_test.sv
// Self-checking bench for one LRU write-back cache set: hit, fill, eviction and writeback.
// Drives the stream ports of lru_write_back_cache_set_top and checks each result beat
// against an in-bench model of the set; uses lwbc_pkg for the address width.
`timescale 1ns / 100ps

module lru_write_back_cache_set_top_test;
   import lwbc_pkg::*;

   localparam int LINE_WAYS        = 8;
   // Each access walks the probe chain, so allow a few whole lookups to settle
   localparam int SETTLE_CYCLES    = 4 * (LINE_WAYS + 2);
   localparam int LONG_HOLD_CYCLES = 400;
   // Worst case is roughly 1700 beats, each a full chain lookup; take it several times over
   localparam int CYCLE_LIMIT      = 600000;

   // What the set should report for one access
   typedef struct packed {
      logic hit;
      logic writeback;
   } access_outcome_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [ADDR_W-1:0]  req_tdata  = '0;   // [31:0] line_address
   logic [0:0]         req_tuser  = '0;   // [0] is_write
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;         // [0] hit, [1] dirty_writeback, [7:2] zero

   // Model of the set: tag, valid, dirty and recency rank per way (rank 0 = most recent)
   logic [ADDR_W-1:0]  line_tag   [LINE_WAYS] = '{default: '0};
   logic               line_valid [LINE_WAYS] = '{default: 1'b0};
   logic               line_dirty [LINE_WAYS] = '{default: 1'b0};
   int                 line_rank  [LINE_WAYS] = '{default: 0};
   int                 lines_filled = 0;

   access_outcome_type outcome_queue[$];

   int                 error_count   = 0;
   int                 cycle_count   = 0;
   bit                 idling_on     = 1'b1;
   bit                 long_hold_req = 1'b0;
   int                 hold_left     = 0;
   int                 stall_left    = 0;

   lru_write_back_cache_set_top #(
      .WAYS (LINE_WAYS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Watchdog: abandon the run if the stream locks up
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, outcome_queue.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Apply one access to the model and return what the set must answer.
   // Hit on the matching valid way; otherwise fill the next empty way, or
   // evict the way with the highest rank once the set is full.
   function automatic access_outcome_type model_access(input logic [ADDR_W-1:0] addr,
                                                       input logic wr);
      access_outcome_type outcome;
      bit                 found;
      int                 way;
      int                 oldest;
      int                 old_rank;
      found = 1'b0;
      way   = 0;
      for (int i = 0; i < LINE_WAYS; i++) begin
         if (!found && line_valid[i] && line_tag[i] == addr) begin
            found = 1'b1;
            way   = i;
         end
      end
      if (!found) begin
         if (lines_filled < LINE_WAYS) begin
            way = lines_filled;
            lines_filled++;
         end else begin
            oldest = 0;
            for (int i = 0; i < LINE_WAYS; i++) begin
               if (line_rank[i] > oldest) begin
                  oldest = line_rank[i];
                  way    = i;
               end
            end
         end
      end
      // Age every valid way that was more recent than the touched one
      old_rank = line_valid[way] ? line_rank[way] : LINE_WAYS;
      for (int i = 0; i < LINE_WAYS; i++) begin
         if (i != way && line_valid[i] && line_rank[i] < old_rank)
            line_rank[i]++;
      end
      line_rank[way] = 0;
      outcome.hit       = found;
      outcome.writeback = !found && line_dirty[way];
      if (!found) begin
         line_tag[way]   = addr;
         line_valid[way] = 1'b1;
      end
      line_dirty[way] = wr || (found && line_dirty[way]);
      return outcome;
   endfunction

   // Offer one access beat, possibly after a random gap, and hold it until taken.
   // The expectation is queued on the accepting edge, well before its result can come.
   task automatic send_access(input logic [ADDR_W-1:0] addr, input logic wr);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= addr;
      req_tuser  <= wr;
      do @(posedge clock); while (req_tready !== 1'b1);
      outcome_queue.push_back(model_access(addr, wr));
   endtask

   // Drop valid and hold until every queued result has come back
   task automatic wait_for_outcomes();
      req_tvalid <= 1'b0;
      while (outcome_queue.size() != 0) @(posedge clock);
   endtask

   task automatic check_outcome(input logic [7:0] beat);
      access_outcome_type want;
      if (outcome_queue.size() == 0) begin
         report_mismatch($sformatf("result beat %h with no access outstanding", beat));
         return;
      end
      want = outcome_queue.pop_front();
      if (beat[0] !== want.hit)
         report_mismatch($sformatf("hit %b, expected %b", beat[0], want.hit));
      if (beat[1] !== want.writeback)
         report_mismatch($sformatf("dirty_writeback %b, expected %b",
                                   beat[1], want.writeback));
   endtask

   // Result side: check each accepted beat, then choose the next tready.
   // A requested long hold-off takes priority over the short random stalls.
   always @(posedge clock) begin
      if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         check_outcome(rsp_tdata);
      if (long_hold_req) begin
         hold_left     = LONG_HOLD_CYCLES;
         long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Fill the set from empty, hit clean and dirty lines, then evict in LRU order:
   // dirty victims must report a writeback, clean ones and empty-way fills must not.
   task automatic test_fill_and_evict();
      send_access(32'h0000_0000, 1'b1);
      send_access(32'hFFFF_FFFF, 1'b0);
      send_access(32'h0000_0000, 1'b0);   // read hit keeps the line dirty
      send_access(32'hFFFF_FFFF, 1'b1);   // write hit marks a clean line dirty
      send_access(32'h5555_5555, 1'b0);
      send_access(32'hAAAA_AAAA, 1'b1);
      send_access(32'h0000_0001, 1'b0);
      send_access(32'h8000_0000, 1'b1);
      send_access(32'h7FFF_FFFF, 1'b0);
      send_access(32'hFFFF_FFFE, 1'b1);   // last empty way filled
      send_access(32'h0000_0002, 1'b0);   // read miss evicts a dirty line
      send_access(32'h1234_5678, 1'b1);   // write miss evicts a dirty line
      send_access(32'hDEAD_BEEF, 1'b0);   // clean victim, new line clean
      send_access(32'hAAAA_AAAA, 1'b0);
      send_access(32'h0000_0000, 1'b0);   // re-fetch of an evicted address
      send_access(32'h8000_0000, 1'b0);   // refresh the oldest line
      send_access(32'hCAFE_F00D, 1'b1);
      send_access(32'h0000_0003, 1'b0);
      send_access(32'h0000_0002, 1'b1);
      send_access(32'h0000_0002, 1'b0);
      send_access(32'hFFFF_FFFF, 1'b1);
      wait_for_outcomes();
   endtask

   // Hold the result side off for a long stretch while beats keep coming,
   // so a finished lookup waits behind the held result and req_tready stays low
   task automatic test_result_backpressure();
      logic [ADDR_W-1:0] hot [5];
      foreach (hot[k]) hot[k] = $urandom();
      long_hold_req = 1'b1;
      for (int n = 0; n < 30; n++)
         send_access(hot[$urandom_range(0, 4)], 1'($urandom_range(0, 1)));
      wait_for_outcomes();
   endtask

   // Pause the request side until the set has answered everything, then resume
   task automatic test_drain_pause();
      for (int n = 0; n < 10; n++)
         send_access($urandom(), 1'($urandom_range(0, 1)));
      wait_for_outcomes();
      for (int n = 0; n < 10; n++)
         send_access($urandom(), 1'($urandom_range(0, 1)));
      wait_for_outcomes();
   endtask

   // Random accesses over a working set whose size changes every hundred beats,
   // so hit rate and eviction pressure vary. Some entries differ from another
   // by one bit to exercise the full tag compare.
   task automatic test_random_traffic(input int count, input bit allow_idle);
      logic [ADDR_W-1:0] pool [16];
      logic [ADDR_W-1:0] addr;
      int                span;
      int                k;
      foreach (pool[j]) pool[j] = $urandom();
      span = 10;
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) begin
            span      = $urandom_range(2, 16);
            idling_on = allow_idle && ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 31) == 0) begin
            k = $urandom_range(0, 15);
            if ($urandom_range(0, 1) == 0)
               pool[k] = $urandom();
            else
               pool[k] = pool[$urandom_range(0, 15)] ^ (32'd1 << $urandom_range(0, 31));
         end
         if ($urandom_range(0, 19) == 0)
            addr = $urandom();
         else
            addr = pool[$urandom_range(0, span - 1)];
         send_access(addr, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      // Hold reset from time zero, then release it once
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_and_evict();
      test_result_backpressure();
      test_drain_pause();
      test_random_traffic(1550, 1'b1);
      // Closing stretch at full rate on both sides
      test_random_traffic(100, 1'b0);

      wait_for_outcomes();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
